// File: sv/bmre_pkg.sv
// ============================================================================
// bmre_pkg: shared types and constants
// State encoding, arithmetic unit opcodes, status codes and register indexes
// for the blockwise mean / RMS statistics block.
// ============================================================================
package bmre_pkg;

    localparam int OUT_W      = 24;        // width of every numeric result
    localparam int RMS_W      = 24;
    localparam int RMS_CAP    = 8388608;   // RMS saturates here
    localparam int FRAC_SH    = 8;         // 8 fraction bits on means
    localparam int RMS_SH     = 16;        // 2 * FRAC_SH, applied before sqrt
    localparam int TENTH_DIV  = 10;
    localparam int RUN_W      = 18;
    localparam int RLEN_W     = 17;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int STAT_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_RUN_SETTING   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_LENGTH = 2'd1;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SHORT  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BADLEN = 2'd2;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef enum logic [3:0] {
        ST_LEN,
        ST_IDLE,
        ST_SQ,
        ST_LQ,
        ST_LL,
        ST_DEVN,
        ST_RMS,
        ST_DEVL,
        ST_MEAN,
        ST_UPD,
        ST_TMEAN,
        ST_TDIV,
        ST_TRMS,
        ST_FIN
    } t_state;

endpackage

// File: sv/bmre_alu.sv
// ============================================================================
// bmre_alu: shared iterative arithmetic unit
// Shift-add multiply, restoring divide and digit-by-digit square root, one
// add/compare step per cycle. Pulses o_done when o_result is valid.
// ============================================================================
module bmre_alu #(
    parameter int W = 82
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bmre_pkg::t_alu_req i_req,
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_b,
    output logic              o_done,
    output logic [W-1:0]      o_result
);
    import bmre_pkg::*;

    localparam int CNT_W = $clog2(W + 1);

    logic              r_busy, r_done;
    t_alu_op           r_op;
    logic [W-1:0]      r_x, r_y, n_x, n_y;
    logic [W:0]        r_z, n_z;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              finish;
    logic [W:0]        div_t;
    logic [W-1:0]      sq_t;

    always_comb begin
        div_t  = {r_z[W-1:0], r_x[W-1]};
        sq_t   = r_z[W-1:0] + r_y;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_cnt  = r_cnt;
        finish = 1'b0;
        unique case (r_op)
            OP_MUL: begin
                if (r_y == '0) begin
                    finish = 1'b1;
                end else begin
                    if (r_y[0]) n_z = r_z + {1'b0, r_x};
                    n_x = r_x << 1;
                    n_y = r_y >> 1;
                end
            end
            OP_DIV: begin
                if (r_cnt == '0) begin
                    finish = 1'b1;
                end else begin
                    if (div_t >= {1'b0, r_y}) begin
                        n_z = div_t - {1'b0, r_y};
                        n_x = {r_x[W-2:0], 1'b1};
                    end else begin
                        n_z = div_t;
                        n_x = {r_x[W-2:0], 1'b0};
                    end
                    n_cnt = r_cnt - 1'b1;
                end
            end
            OP_SQRT: begin
                // r_x remainder, r_z root, r_y current bit
                if (r_y == '0) begin
                    finish = 1'b1;
                end else begin
                    if (r_x >= sq_t) begin
                        n_x = r_x - sq_t;
                        n_z = {1'b0, (r_z[W-1:0] >> 1) + r_y};
                    end else begin
                        n_z = {1'b0, r_z[W-1:0] >> 1};
                    end
                    n_y = r_y >> 2;
                end
            end
            default: finish = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
            end else if (r_busy && finish) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= i_a;
            r_z   <= '0;
            r_cnt <= CNT_W'(W);
            if (i_req.op == OP_SQRT) r_y <= W'(1) << (W - 2);
            else                     r_y <= i_b;
        end else if (r_busy) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_cnt <= n_cnt;
        end
    end

    assign o_done   = r_done;
    assign o_result = (r_op == OP_DIV) ? r_x : r_z[W-1:0];

endmodule

// File: sv/block_mean_rms_extremes.sv
// ============================================================================
// block_mean_rms_extremes: blockwise mean / RMS statistics over a record
// Accumulates signed samples, closes fixed-length blocks, tracks extremes of
// block mean and RMS, and reports them with total mean and pooled RMS.
// ============================================================================
// A sample that neither closes its block nor ends the record is taken in the
// idle state, and the block stays ready for the next sample while no
// configuration write is pending. Closing a block runs a sequence on one
// shared shift-add / subtract unit (bmre_alu). The sequence is three
// multiplies, each one step per significant bit of its second operand. It
// then runs three divides of ALU_W steps and one square root of ALU_W/2
// steps, and one more state (ST_UPD) folds the block in. The last sample of
// a record with status ok adds two divides and a square root more before
// the result is written to the output register; the result then waits
// there while the next record streams in. After reset and after each write
// to the run setting or record length register the block length is
// resolved with one divide, or directly when the setting gives the length,
// before the first sample is taken. Writing either register restarts the
// record. Samples past the last complete block count toward the record but
// are otherwise ignored. A status other than ok yields a result whose other
// fields are all zero.
module block_mean_rms_extremes #(
    parameter int RECORD_MAX  = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bmre_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bmre_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // sample input
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample,
    // result output
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [bmre_pkg::STAT_W-1:0]          o_status,
    output logic signed [bmre_pkg::OUT_W-1:0]    o_min_mean,
    output logic signed [bmre_pkg::OUT_W-1:0]    o_max_mean,
    output logic [bmre_pkg::OUT_W-1:0]           o_min_rms,
    output logic [bmre_pkg::OUT_W-1:0]           o_max_rms,
    output logic signed [bmre_pkg::OUT_W-1:0]    o_total_mean,
    output logic [bmre_pkg::OUT_W-1:0]           o_total_rms
);
    import bmre_pkg::*;

    localparam int LEN_W  = $clog2(RECORD_MAX + 1);
    localparam int SUM_W  = SAMPLE_BITS + LEN_W;
    localparam int SQ_W   = 2 * SAMPLE_BITS + LEN_W;
    localparam int TD_W   = 2 * SAMPLE_BITS + LEN_W;
    localparam int MEAN_W = SAMPLE_BITS + FRAC_SH + 1;
    localparam int ALU_W  = 2 * SAMPLE_BITS + 2 * LEN_W + RMS_SH;

    t_state r_state, n_state;

    // configuration
    logic signed [RUN_W-1:0]  r_run;
    logic [RLEN_W-1:0]        r_rlen;
    logic [LEN_W-1:0]         r_len;
    logic [LEN_W-1:0]         rec_n;
    logic signed [31:0]       run_w, n_w;
    logic                     len_tenth, len_neg, len_direct;
    logic [RUN_W-1:0]         run_mag;
    logic [STAT_W-1:0]        stat;

    // accumulators
    logic signed [SUM_W-1:0]  r_bsum, r_tsum, n_bsum;
    logic [SQ_W-1:0]          r_bsq, n_bsq;
    logic [LEN_W-1:0]         r_bfill, r_rfill;
    logic [TD_W-1:0]          r_tdev;
    logic signed [MEAN_W-1:0] r_mmin, r_mmax, r_mean, r_tm;
    logic [RMS_W-1:0]         r_rmin, r_rmax, r_rms, r_trms;
    logic                     r_first, r_rec_end;

    // scratch for the close sequence
    logic [ALU_W-1:0]         r_s2, r_v, r_ll;

    // sample path
    logic signed [2*SAMPLE_BITS-1:0] x_sq;
    logic                     blk_close, rec_end;
    logic [SUM_W-1:0]         bsum_mag, tsum_mag;

    // shared unit
    t_alu_req                 alu_req;
    logic [ALU_W-1:0]         alu_a, alu_b, alu_res, alu_q;
    logic                     alu_done, r_issued, alu_state;
    logic [RMS_W-1:0]         rms_cap;

    // handshakes
    logic                     cfg_acc, cfg_hit, in_acc, out_free;
    logic                     r_ovalid;
    logic [STAT_W-1:0]        r_ostat;
    logic signed [OUT_W-1:0]  r_omin_m, r_omax_m, r_otm;
    logic [OUT_W-1:0]         r_omin_r, r_omax_r, r_otr;

    bmre_alu #(.W(ALU_W)) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_done   (alu_done),
        .o_result (alu_res)
    );

    // ---- record and block length resolution --------------------------------
    always_comb begin
        if (r_rlen == '0)                  rec_n = LEN_W'(1);
        else if (32'(r_rlen) > RECORD_MAX) rec_n = LEN_W'(RECORD_MAX);
        else                               rec_n = LEN_W'(r_rlen);
    end

    assign run_w      = 32'(r_run);
    assign n_w        = signed'(32'(rec_n));
    assign len_tenth  = (r_run == '0) || (run_w > n_w);
    assign len_neg    = r_run < 0;
    assign len_direct = !len_tenth && !len_neg;
    assign run_mag    = RUN_W'(-r_run);

    always_comb begin
        if (rec_n < LEN_W'(2))                  stat = STAT_SHORT;
        else if (r_len == '0 || r_len >= rec_n) stat = STAT_BADLEN;
        else                                    stat = STAT_OK;
    end

    // ---- handshakes ----------------------------------------------------------
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_ready     = (r_state == ST_IDLE) && !i_cfg_valid;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign cfg_hit     = cfg_acc && (i_cfg_index == REG_RUN_SETTING ||
                                     i_cfg_index == REG_RECORD_LENGTH);
    assign in_acc      = i_valid && o_ready;
    assign out_free    = !r_ovalid || i_ready;

    // ---- sample path ---------------------------------------------------------
    assign x_sq      = i_sample * i_sample;
    assign n_bsum    = r_bsum + SUM_W'(i_sample);
    assign n_bsq     = r_bsq + SQ_W'($unsigned(x_sq));
    assign blk_close = (r_bfill + 1'b1) >= r_len;
    assign rec_end   = (r_rfill + 1'b1) >= rec_n;
    assign bsum_mag  = r_bsum < 0 ? SUM_W'(-r_bsum) : SUM_W'(r_bsum);
    assign tsum_mag  = r_tsum < 0 ? SUM_W'(-r_tsum) : SUM_W'(r_tsum);

    // ---- next state ------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LEN:   if (len_direct || alu_done) n_state = ST_IDLE;
            ST_IDLE: begin
                if (cfg_hit) begin
                    n_state = ST_LEN;
                end else if (in_acc) begin
                    if (stat == STAT_OK && blk_close) n_state = ST_SQ;
                    else if (rec_end)
                        n_state = (stat == STAT_OK) ? ST_TMEAN : ST_FIN;
                end
            end
            ST_SQ:    if (alu_done) n_state = ST_LQ;
            ST_LQ:    if (alu_done) n_state = ST_LL;
            ST_LL:    if (alu_done) n_state = ST_DEVN;
            ST_DEVN:  if (alu_done) n_state = ST_RMS;
            ST_RMS:   if (alu_done) n_state = ST_DEVL;
            ST_DEVL:  if (alu_done) n_state = ST_MEAN;
            ST_MEAN:  if (alu_done) n_state = ST_UPD;
            ST_UPD:   n_state = r_rec_end ? ST_TMEAN : ST_IDLE;
            ST_TMEAN: if (alu_done) n_state = ST_TDIV;
            ST_TDIV:  if (alu_done) n_state = ST_TRMS;
            ST_TRMS:  if (alu_done) n_state = ST_FIN;
            ST_FIN:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // ---- shared unit requests ------------------------------------------------
    always_comb begin
        alu_state  = 1'b1;
        alu_req.op = OP_DIV;
        alu_a      = '0;
        alu_b      = '0;
        unique case (r_state)
            ST_LEN: begin
                alu_a = ALU_W'(rec_n);
                alu_b = len_tenth ? ALU_W'(TENTH_DIV) : ALU_W'(run_mag);
            end
            ST_SQ: begin
                alu_req.op = OP_MUL;
                alu_a      = ALU_W'(bsum_mag);
                alu_b      = ALU_W'(bsum_mag);
            end
            ST_LQ: begin
                alu_req.op = OP_MUL;
                alu_a      = ALU_W'(r_bsq);
                alu_b      = ALU_W'(r_len);
            end
            ST_LL: begin
                alu_req.op = OP_MUL;
                alu_a      = ALU_W'(r_len);
                alu_b      = ALU_W'(r_len);
            end
            ST_DEVN: begin
                alu_a = r_v << RMS_SH;
                alu_b = r_ll;
            end
            ST_RMS: begin
                alu_req.op = OP_SQRT;
                alu_a      = r_s2;
            end
            ST_DEVL: begin
                alu_a = r_v;
                alu_b = ALU_W'(r_len);
            end
            ST_MEAN: begin
                alu_a = ALU_W'(bsum_mag) << FRAC_SH;
                alu_b = ALU_W'(r_len);
            end
            ST_TMEAN: begin
                alu_a = ALU_W'(tsum_mag) << FRAC_SH;
                alu_b = ALU_W'(rec_n);
            end
            ST_TDIV: begin
                alu_a = ALU_W'(r_tdev) << RMS_SH;
                alu_b = ALU_W'(rec_n - 1'b1);
            end
            ST_TRMS: begin
                alu_req.op = OP_SQRT;
                alu_a      = r_s2;
            end
            default: alu_state = 1'b0;
        endcase
        alu_req.start = alu_state && !r_issued && !(r_state == ST_LEN && len_direct);
    end

    assign alu_q   = alu_res;
    assign rms_cap = (alu_res > ALU_W'(RMS_CAP)) ? RMS_W'(RMS_CAP) : alu_res[RMS_W-1:0];

    // ---- control and accumulators --------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LEN;
            r_issued  <= 1'b0;
            r_run     <= '0;
            r_rlen    <= RLEN_W'(1024);
            r_len     <= '0;
            r_bsum    <= '0;
            r_bsq     <= '0;
            r_bfill   <= '0;
            r_rfill   <= '0;
            r_tsum    <= '0;
            r_tdev    <= '0;
            r_mmin    <= '0;
            r_mmax    <= '0;
            r_rmin    <= '0;
            r_rmax    <= '0;
            r_first   <= 1'b1;
            r_rec_end <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (alu_done)           r_issued <= 1'b0;
            else if (alu_req.start) r_issued <= 1'b1;

            // a new result may replace one taken on this same edge
            if (r_state == ST_FIN && out_free) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready)      r_ovalid <= 1'b0;

            unique case (r_state)
                ST_LEN: begin
                    if (len_direct)    r_len <= LEN_W'(r_run);
                    else if (alu_done) r_len <= LEN_W'(alu_q);
                end
                ST_IDLE: begin
                    if (cfg_hit) begin
                        if (i_cfg_index == REG_RUN_SETTING) r_run <= i_cfg_data;
                        else r_rlen <= i_cfg_data[RLEN_W-1:0];
                        r_bsum  <= '0;
                        r_bsq   <= '0;
                        r_bfill <= '0;
                        r_rfill <= '0;
                        r_tsum  <= '0;
                        r_tdev  <= '0;
                        r_mmin  <= '0;
                        r_mmax  <= '0;
                        r_rmin  <= '0;
                        r_rmax  <= '0;
                        r_first <= 1'b1;
                    end else if (in_acc) begin
                        r_rfill   <= r_rfill + 1'b1;
                        r_rec_end <= rec_end;
                        if (stat == STAT_OK) begin
                            r_bsum  <= n_bsum;
                            r_bsq   <= n_bsq;
                            r_bfill <= r_bfill + 1'b1;
                        end
                    end
                end
                ST_DEVL: if (alu_done) r_tdev <= r_tdev + TD_W'(alu_q);
                ST_UPD: begin
                    // fold this block into the extremes and the total sum
                    if (r_first || r_mean < r_mmin) r_mmin <= r_mean;
                    if (r_first || r_mean > r_mmax) r_mmax <= r_mean;
                    if (r_first || r_rms < r_rmin)  r_rmin <= r_rms;
                    if (r_first || r_rms > r_rmax)  r_rmax <= r_rms;
                    r_first <= 1'b0;
                    r_tsum  <= r_tsum + r_bsum;
                    r_bsum  <= '0;
                    r_bsq   <= '0;
                    r_bfill <= '0;
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_bsum   <= '0;
                        r_bsq    <= '0;
                        r_bfill  <= '0;
                        r_rfill  <= '0;
                        r_tsum   <= '0;
                        r_tdev   <= '0;
                        r_mmin   <= '0;
                        r_mmax   <= '0;
                        r_rmin   <= '0;
                        r_rmax   <= '0;
                        r_first  <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---- datapath scratch and output register --------------------------------
    always_ff @(posedge i_clk) begin
        if (alu_done) begin
            unique case (r_state)
                ST_SQ:    r_s2 <= alu_q;
                ST_LQ:    r_v  <= (alu_q > r_s2) ? alu_q - r_s2 : '0;
                ST_LL:    r_ll <= alu_q;
                ST_DEVN:  r_s2 <= alu_q;
                ST_RMS:   r_rms <= rms_cap;
                ST_MEAN:  r_mean <= (r_bsum < 0) ? -MEAN_W'(alu_q) : MEAN_W'(alu_q);
                ST_TMEAN: r_tm <= (r_tsum < 0) ? -MEAN_W'(alu_q) : MEAN_W'(alu_q);
                ST_TDIV:  r_s2 <= alu_q;
                ST_TRMS:  r_trms <= rms_cap;
                default: ;
            endcase
        end
        if (r_state == ST_FIN && out_free) begin
            r_ostat <= stat;
            if (stat == STAT_OK) begin
                r_omin_m <= OUT_W'(r_mmin);
                r_omax_m <= OUT_W'(r_mmax);
                r_omin_r <= OUT_W'(r_rmin);
                r_omax_r <= OUT_W'(r_rmax);
                r_otm    <= OUT_W'(r_tm);
                r_otr    <= OUT_W'(r_trms);
            end else begin
                r_omin_m <= '0;
                r_omax_m <= '0;
                r_omin_r <= '0;
                r_omax_r <= '0;
                r_otm    <= '0;
                r_otr    <= '0;
            end
        end
    end

    assign o_valid      = r_ovalid;
    assign o_status     = r_ostat;
    assign o_min_mean   = r_omin_m;
    assign o_max_mean   = r_omax_m;
    assign o_min_rms    = r_omin_r;
    assign o_max_rms    = r_omax_r;
    assign o_total_mean = r_otm;
    assign o_total_rms  = r_otr;

endmodule

// File: sv/bmre_checker.sv
// ============================================================================
// bmre_checker: port-level checks for block_mean_rms_extremes
// Watches the result channel for hold behavior and result consistency.
// ============================================================================
module bmre_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic [bmre_pkg::STAT_W-1:0]        o_status,
    input logic signed [bmre_pkg::OUT_W-1:0]  o_min_mean,
    input logic signed [bmre_pkg::OUT_W-1:0]  o_max_mean,
    input logic [bmre_pkg::OUT_W-1:0]         o_min_rms,
    input logic [bmre_pkg::OUT_W-1:0]         o_max_rms,
    input logic signed [bmre_pkg::OUT_W-1:0]  o_total_mean,
    input logic [bmre_pkg::OUT_W-1:0]         o_total_rms
);
    import bmre_pkg::*;

    // a stalled result holds its status, its RMS extremes and its total RMS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_min_rms)
            && $stable(o_max_rms) && $stable(o_total_rms))
        else $error("result changed while stalled");

    // a failed record carries only its status
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STAT_OK |-> o_min_mean == 0 && o_max_mean == 0
            && o_min_rms == 0 && o_max_rms == 0 && o_total_mean == 0
            && o_total_rms == 0)
        else $error("nonzero fields with failed status");

    // extremes are ordered on a good record
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STAT_OK |-> o_min_mean <= o_max_mean
            && o_min_rms <= o_max_rms)
        else $error("extremes out of order");

    // RMS values never pass the saturation point
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_max_rms <= OUT_W'(RMS_CAP) && o_total_rms <= OUT_W'(RMS_CAP))
        else $error("RMS above cap");

endmodule

bind block_mean_rms_extremes bmre_checker u_bmre_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_status     (o_status),
    .o_min_mean   (o_min_mean),
    .o_max_mean   (o_max_mean),
    .o_min_rms    (o_min_rms),
    .o_max_rms    (o_max_rms),
    .o_total_mean (o_total_mean),
    .o_total_rms  (o_total_rms)
);
